FILE: src/itsq_pkg.sv
// ----------------------------------------------------------------------------
// itsq_pkg
// Shared widths, codes and defaults for the interval timer sequencer.
// ----------------------------------------------------------------------------
package itsq_pkg;

  localparam int RND_W  = 16;   // random draw width
  localparam int LEN_W  = 8;    // phase lengths, counts
  localparam int DIV_W  = LEN_W + 1;  // hi - lo + 1 reaches 256
  localparam int CFG_IW = 3;

  localparam int START_COUNT_DEF  = 5;
  localparam int WARN_SECONDS_DEF = 3;

  // event codes
  localparam logic [1:0] EV_TICK  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_PAUSE = 2'd2;
  localparam logic [1:0] EV_SKIP  = 2'd3;

  // phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_WORK   = 3'd2;
  localparam logic [2:0] PH_REST   = 3'd3;
  localparam logic [2:0] PH_WORK_P = 3'd4;
  localparam logic [2:0] PH_REST_P = 3'd5;

  // beep codes
  localparam logic [2:0] BP_NONE  = 3'd0;
  localparam logic [2:0] BP_START = 3'd1;
  localparam logic [2:0] BP_REST  = 3'd2;
  localparam logic [2:0] BP_SWARN = 3'd3;
  localparam logic [2:0] BP_EWARN = 3'd4;
  localparam logic [2:0] BP_DONE  = 3'd5;

  // repeat modes
  localparam logic [1:0] RM_FOREVER = 2'd0;
  localparam logic [1:0] RM_ROUNDS  = 2'd1;
  localparam logic [1:0] RM_SECONDS = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_WORK_MIN   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WORK_MAX   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_REST_MIN   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_REST_MAX   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REPEAT_MD  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_REPEAT_LIM = 3'd5;
  localparam logic [CFG_IW-1:0] REG_START_WARN = 3'd6;
  localparam logic [CFG_IW-1:0] REG_END_WARN   = 3'd7;

endpackage

FILE: src/itsq_rem_unit.sv
// ----------------------------------------------------------------------------
// itsq_rem_unit
// Restoring remainder unit: one dividend bit per cycle, over all RND_W dividend bits.
// ----------------------------------------------------------------------------
module itsq_rem_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [itsq_pkg::RND_W-1:0]      dividend,
  input  logic [itsq_pkg::DIV_W-1:0]      divisor,
  output logic                            busy,
  output logic                            done,
  output logic [itsq_pkg::LEN_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(itsq_pkg::RND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(itsq_pkg::RND_W - 1);

  logic [itsq_pkg::RND_W-1:0] dvd;
  logic [itsq_pkg::DIV_W-1:0] dvs;
  logic [itsq_pkg::LEN_W-1:0] rem;
  logic [CNT_W-1:0]           cnt;
  logic [itsq_pkg::DIV_W-1:0] shifted;
  logic [itsq_pkg::DIV_W-1:0] diff;
  logic [itsq_pkg::LEN_W-1:0] rem_next;

  assign shifted  = {rem, dvd[itsq_pkg::RND_W-1]};
  assign diff     = shifted - dvs;
  // partial remainder stays below the divisor, so it fits LEN_W bits
  assign rem_next = (shifted >= dvs) ? diff[itsq_pkg::LEN_W-1:0]
                                     : shifted[itsq_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[itsq_pkg::RND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (done && dvs != '0) |-> ({1'b0, rem} < dvs))
    else $error("remainder not below divisor");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("start while division is running");

endmodule

FILE: src/interval_timer_sequencer.sv
// ----------------------------------------------------------------------------
// interval_timer_sequencer
// Work/rest interval timer with optional precount, random phase lengths
// and a round or seconds limit. One result per event.
// ----------------------------------------------------------------------------
// An accepted event launches the bit-serial remainder draw; its result is
//   registered on commit, once the draw is done and the output is free.
// Input stall stays high while busy, so a new event waits until the last commits.
// A pending result holds in the output register while the next event runs.
// Reset (rst, synchronous): idle phase, counters zero, registers to defaults.
module interval_timer_sequencer #(
  parameter int START_COUNT  = itsq_pkg::START_COUNT_DEF,
  parameter int WARN_SECONDS = itsq_pkg::WARN_SECONDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [itsq_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [itsq_pkg::LEN_W-1:0]        cfg_data,
  // event channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [itsq_pkg::RND_W-1:0]        random_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        phase,
  output logic [itsq_pkg::LEN_W-1:0]        time_left,
  output logic [itsq_pkg::LEN_W-1:0]        limit_left,
  output logic [2:0]                        beep
);

  localparam int LW = itsq_pkg::LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_HOLD} state_t;

  state_t state;

  // configuration
  logic [LW-1:0] work_min, work_max, rest_min, rest_max, repeat_limit;
  logic [1:0]    repeat_mode;
  logic          start_warn_on, end_warn_on;

  // timer state
  logic [2:0]    phase_reg;
  logic [LW-1:0] work_left, rest_left, precount_left, limit_count;

  // captured event
  logic [1:0]    ev;
  logic          sel_rest;

  // remainder unit
  logic                        rem_start, rem_busy, rem_done;
  logic [itsq_pkg::DIV_W-1:0]  rem_divisor;
  logic [LW-1:0]               rem_value;

  // next-state values
  logic [2:0]    phase_next, beep_next;
  logic [LW-1:0] work_left_next, rest_left_next, precount_left_next, limit_count_next;
  logic [LW-1:0] time_left_next, limit_dec, draw_len, lo_sel, hi_sel;
  logic [LW-1:0] work_dec, rest_dec;
  logic          in_xfer, commit, counting;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign commit    = (state == S_HOLD) && (!out_valid || !out_stall);

  // bounds for the draw: a tick during work draws rest, anything else draws work
  logic          draw_rest_now;
  logic [LW-1:0] lo_now, hi_now;
  assign draw_rest_now = (mode == itsq_pkg::EV_TICK) && (phase_reg == itsq_pkg::PH_WORK);
  assign lo_now        = draw_rest_now ? rest_min : work_min;
  assign hi_now        = draw_rest_now ? rest_max : work_max;
  assign rem_start     = in_xfer;
  assign rem_divisor   = {1'b0, hi_now} - {1'b0, lo_now} + 1'b1;

  itsq_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (random_value),
    .divisor   (rem_divisor),
    .busy      (rem_busy),
    .done      (rem_done),
    .remainder (rem_value)
  );

  assign lo_sel    = sel_rest ? rest_min : work_min;
  assign hi_sel    = sel_rest ? rest_max : work_max;
  assign draw_len  = (hi_sel <= lo_sel) ? lo_sel : lo_sel + rem_value;
  assign limit_dec = (limit_count != '0) ? limit_count - 1'b1 : '0;
  assign work_dec  = work_left - 1'b1;
  assign rest_dec  = rest_left - 1'b1;
  assign counting  = (repeat_mode == itsq_pkg::RM_ROUNDS) ||
                     (repeat_mode == itsq_pkg::RM_SECONDS);

  always_comb begin
    phase_next         = phase_reg;
    work_left_next     = work_left;
    rest_left_next     = rest_left;
    precount_left_next = precount_left;
    limit_count_next   = limit_count;
    beep_next          = itsq_pkg::BP_NONE;
    unique case (ev)
      itsq_pkg::EV_START: begin
        work_left_next   = draw_len;
        limit_count_next = repeat_limit;
        if (start_warn_on) begin
          phase_next         = itsq_pkg::PH_PRE;
          precount_left_next = LW'(START_COUNT);
        end else begin
          phase_next = itsq_pkg::PH_WORK;
        end
      end
      itsq_pkg::EV_PAUSE: begin
        unique case (phase_reg)
          itsq_pkg::PH_WORK:   phase_next = itsq_pkg::PH_WORK_P;
          itsq_pkg::PH_REST:   phase_next = itsq_pkg::PH_REST_P;
          itsq_pkg::PH_WORK_P: phase_next = itsq_pkg::PH_WORK;
          itsq_pkg::PH_REST_P: phase_next = itsq_pkg::PH_REST;
          default:             phase_next = phase_reg;
        endcase
      end
      itsq_pkg::EV_SKIP: begin
        if (phase_reg == itsq_pkg::PH_WORK) work_left_next = '0;
        else if (phase_reg == itsq_pkg::PH_REST) rest_left_next = '0;
      end
      default: begin
        if (phase_reg == itsq_pkg::PH_PRE) begin
          if (precount_left > LW'(1)) begin
            precount_left_next = precount_left - 1'b1;
            beep_next          = itsq_pkg::BP_SWARN;
          end else begin
            phase_next = itsq_pkg::PH_WORK;
            beep_next  = itsq_pkg::BP_START;
          end
        end else if (phase_reg == itsq_pkg::PH_WORK) begin
          if (work_left != '0) begin
            work_left_next = work_dec;
            if (end_warn_on && ({1'b0, work_dec} < (LW+1)'(WARN_SECONDS)))
              beep_next = itsq_pkg::BP_EWARN;
          end else begin
            phase_next     = itsq_pkg::PH_REST;
            rest_left_next = draw_len;
            if (repeat_mode == itsq_pkg::RM_ROUNDS) limit_count_next = limit_dec;
            beep_next      = itsq_pkg::BP_REST;
          end
          if (repeat_mode == itsq_pkg::RM_SECONDS) limit_count_next = limit_dec;
        end else if (phase_reg == itsq_pkg::PH_REST) begin
          if (rest_left != '0) begin
            rest_left_next = rest_dec;
            if (start_warn_on && ({1'b0, rest_dec} < (LW+1)'(WARN_SECONDS)))
              beep_next = itsq_pkg::BP_SWARN;
          end else begin
            phase_next     = itsq_pkg::PH_WORK;
            work_left_next = draw_len;
            beep_next      = itsq_pkg::BP_START;
          end
          if (repeat_mode == itsq_pkg::RM_SECONDS) limit_count_next = limit_dec;
        end
      end
    endcase

    // limit reached: stop, and announce it if a run was active
    if (counting && limit_count_next == '0) begin
      if (phase_next == itsq_pkg::PH_WORK || phase_next == itsq_pkg::PH_REST)
        beep_next = itsq_pkg::BP_DONE;
      phase_next = itsq_pkg::PH_IDLE;
    end

    if (phase_next == itsq_pkg::PH_PRE)
      time_left_next = precount_left_next;
    else if (phase_next == itsq_pkg::PH_WORK || phase_next == itsq_pkg::PH_WORK_P)
      time_left_next = work_left_next;
    else if (phase_next == itsq_pkg::PH_REST || phase_next == itsq_pkg::PH_REST_P)
      time_left_next = rest_left_next;
    else
      time_left_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      work_min      <= LW'(10);
      work_max      <= LW'(60);
      rest_min      <= LW'(5);
      rest_max      <= LW'(30);
      repeat_mode   <= itsq_pkg::RM_ROUNDS;
      repeat_limit  <= LW'(3);
      start_warn_on <= 1'b1;
      end_warn_on   <= 1'b1;
      phase_reg     <= itsq_pkg::PH_IDLE;
      work_left     <= '0;
      rest_left     <= '0;
      precount_left <= '0;
      limit_count   <= '0;
      ev            <= itsq_pkg::EV_TICK;
      sel_rest      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          itsq_pkg::REG_WORK_MIN:   work_min      <= cfg_data;
          itsq_pkg::REG_WORK_MAX:   work_max      <= cfg_data;
          itsq_pkg::REG_REST_MIN:   rest_min      <= cfg_data;
          itsq_pkg::REG_REST_MAX:   rest_max      <= cfg_data;
          itsq_pkg::REG_REPEAT_MD:  repeat_mode   <= cfg_data[1:0];
          itsq_pkg::REG_REPEAT_LIM: repeat_limit  <= cfg_data;
          itsq_pkg::REG_START_WARN: start_warn_on <= cfg_data[0];
          itsq_pkg::REG_END_WARN:   end_warn_on   <= cfg_data[0];
          default: ;
        endcase
      end

      // raise a result on commit, drop it once its transfer completes
      if (commit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            ev       <= mode;
            sel_rest <= draw_rest_now;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          if (rem_done) state <= S_HOLD;
        end
        S_HOLD: begin
          if (commit) begin
            phase_reg     <= phase_next;
            work_left     <= work_left_next;
            rest_left     <= rest_left_next;
            precount_left <= precount_left_next;
            limit_count   <= limit_count_next;
            phase         <= phase_next;
            time_left     <= time_left_next;
            limit_left    <= limit_count_next;
            beep          <= beep_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_calc_runs_divider: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && !rem_done) |-> rem_busy)
    else $error("sequencer waiting on an idle remainder unit");

  a_accept_starts_calc: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_CALC))
    else $error("accepted event did not start a draw");

  a_limit_stops: assert property (@(posedge clk) disable iff (rst)
    (commit && counting && limit_count_next == '0) |=> (phase_reg == itsq_pkg::PH_IDLE))
    else $error("timer kept running with exhausted limit");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    commit |=> (phase_reg <= itsq_pkg::PH_REST_P))
    else $error("phase register out of range");

endmodule

FILE: sim/interval_timer_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_timer_sequencer_tb
// Self-checking bench for the work/rest interval timer. A queue-fed driver
// offers timer events (tick, start, pause, skip), and a monitor predicts each
// result from its own copy of the timer state and configuration. It then
// compares every result field by field. A directed opening runs on the reset
// defaults. Random segments follow, each under a different register setting,
// with random idling on both channels in six, and one long result stall.
// ----------------------------------------------------------------------------
module interval_timer_sequencer_tb;

  localparam int START_COUNT  = itsq_pkg::START_COUNT_DEF;
  localparam int WARN_SECONDS = itsq_pkg::WARN_SECONDS_DEF;
  localparam int HALF_PERIOD  = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int SEG_EVENTS   = 160;

  typedef struct packed {
    logic [1:0]  ev;
    logic [15:0] rnd;
  } timer_event_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] time_left;
    logic [7:0] limit_left;
    logic [2:0] beep;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = itsq_pkg::EV_TICK;
  logic [15:0] random_value = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  phase;
  logic [7:0]  time_left;
  logic [7:0]  limit_left;
  logic [2:0]  beep;

  // configuration copy
  logic [7:0] cfg_work_min    = 8'd10;
  logic [7:0] cfg_work_max    = 8'd60;
  logic [7:0] cfg_rest_min    = 8'd5;
  logic [7:0] cfg_rest_max    = 8'd30;
  logic [1:0] cfg_repeat_mode = itsq_pkg::RM_ROUNDS;
  logic [7:0] cfg_repeat_lim  = 8'd3;
  logic       cfg_start_warn  = 1'b1;
  logic       cfg_end_warn    = 1'b1;

  // timer state copy
  logic [2:0] cur_phase = itsq_pkg::PH_IDLE;
  logic [7:0] work_cnt  = '0;
  logic [7:0] rest_cnt  = '0;
  logic [7:0] pre_cnt   = '0;
  logic [7:0] limit_cnt = '0;

  timer_event_t  pending_q[$];
  timer_result_t expected_q[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  int send_idle_pct = 25;
  int stall_pct     = 69;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  logic event_taken = 1'b0;

  interval_timer_sequencer #(
    .START_COUNT  (START_COUNT),
    .WARN_SECONDS (WARN_SECONDS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phase        (phase),
    .time_left    (time_left),
    .limit_left   (limit_left),
    .beep         (beep)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] pick_length(logic [7:0] lo, logic [7:0] hi,
                                              logic [15:0] rnd);
    int span;
    if (hi <= lo) return lo;
    span = int'(hi) - int'(lo) + 1;
    return 8'(int'(lo) + int'(rnd) % span);
  endfunction

  function automatic logic [7:0] sat_dec(logic [7:0] v);
    return (v == 8'd0) ? 8'd0 : v - 8'd1;
  endfunction

  task automatic timer_step(input logic [1:0] ev, input logic [15:0] rnd);
    logic [2:0] bp;
    timer_result_t r;
    bp = itsq_pkg::BP_NONE;
    case (ev)
      itsq_pkg::EV_START: begin
        work_cnt  = pick_length(cfg_work_min, cfg_work_max, rnd);
        limit_cnt = cfg_repeat_lim;
        if (cfg_start_warn) begin
          cur_phase = itsq_pkg::PH_PRE;
          pre_cnt   = 8'(START_COUNT);
        end else begin
          cur_phase = itsq_pkg::PH_WORK;
        end
      end
      itsq_pkg::EV_PAUSE: begin
        case (cur_phase)
          itsq_pkg::PH_WORK:   cur_phase = itsq_pkg::PH_WORK_P;
          itsq_pkg::PH_REST:   cur_phase = itsq_pkg::PH_REST_P;
          itsq_pkg::PH_WORK_P: cur_phase = itsq_pkg::PH_WORK;
          itsq_pkg::PH_REST_P: cur_phase = itsq_pkg::PH_REST;
          default: ;
        endcase
      end
      itsq_pkg::EV_SKIP: begin
        if (cur_phase == itsq_pkg::PH_WORK) work_cnt = '0;
        else if (cur_phase == itsq_pkg::PH_REST) rest_cnt = '0;
      end
      default: begin
        if (cur_phase == itsq_pkg::PH_PRE) begin
          if (pre_cnt > 8'd1) begin
            pre_cnt = pre_cnt - 8'd1;
            bp = itsq_pkg::BP_SWARN;
          end else begin
            cur_phase = itsq_pkg::PH_WORK;
            bp = itsq_pkg::BP_START;
          end
        end else if (cur_phase == itsq_pkg::PH_WORK) begin
          if (work_cnt > 8'd0) begin
            work_cnt = work_cnt - 8'd1;
            if (cfg_end_warn && int'(work_cnt) < WARN_SECONDS) bp = itsq_pkg::BP_EWARN;
          end else begin
            cur_phase = itsq_pkg::PH_REST;
            rest_cnt  = pick_length(cfg_rest_min, cfg_rest_max, rnd);
            if (cfg_repeat_mode == itsq_pkg::RM_ROUNDS) limit_cnt = sat_dec(limit_cnt);
            bp = itsq_pkg::BP_REST;
          end
          if (cfg_repeat_mode == itsq_pkg::RM_SECONDS) limit_cnt = sat_dec(limit_cnt);
        end else if (cur_phase == itsq_pkg::PH_REST) begin
          if (rest_cnt > 8'd0) begin
            rest_cnt = rest_cnt - 8'd1;
            if (cfg_start_warn && int'(rest_cnt) < WARN_SECONDS) bp = itsq_pkg::BP_SWARN;
          end else begin
            cur_phase = itsq_pkg::PH_WORK;
            work_cnt  = pick_length(cfg_work_min, cfg_work_max, rnd);
            bp = itsq_pkg::BP_START;
          end
          if (cfg_repeat_mode == itsq_pkg::RM_SECONDS) limit_cnt = sat_dec(limit_cnt);
        end
      end
    endcase

    // stop on an exhausted limit; finished overrides any other beep
    if ((cfg_repeat_mode == itsq_pkg::RM_ROUNDS || cfg_repeat_mode == itsq_pkg::RM_SECONDS) &&
        limit_cnt == 8'd0) begin
      if (cur_phase == itsq_pkg::PH_WORK || cur_phase == itsq_pkg::PH_REST)
        bp = itsq_pkg::BP_DONE;
      cur_phase = itsq_pkg::PH_IDLE;
    end

    r.phase = cur_phase;
    case (cur_phase)
      itsq_pkg::PH_PRE:                     r.time_left = pre_cnt;
      itsq_pkg::PH_WORK, itsq_pkg::PH_WORK_P: r.time_left = work_cnt;
      itsq_pkg::PH_REST, itsq_pkg::PH_REST_P: r.time_left = rest_cnt;
      default:                              r.time_left = '0;
    endcase
    r.limit_left = limit_cnt;
    r.beep = bp;
    expected_q.push_back(r);
  endtask

  // ------------------------------------------------------------ driver side
  always @(negedge clk) begin
    timer_event_t nxt;
    if (!in_valid || event_taken) begin
      if (!rst && pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        in_valid     <= 1'b1;
        mode         <= nxt.ev;
        random_value <= nxt.rnd;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with an occasional long hold
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    event_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        timer_step(mode, random_value);
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, %s %0d time %0d limit %0d beep %0d",
                   $time, "actual phase", phase, time_left, limit_left, beep);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("phase", int'(want.phase), int'(phase));
          check_field("time_left", int'(want.time_left), int'(time_left));
          check_field("limit_left", int'(want.limit_left), int'(limit_left));
          check_field("beep", int'(want.beep), int'(beep));
        end
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic queue_event(input logic [1:0] ev, input logic [15:0] rnd);
    timer_event_t e;
    e.ev  = ev;
    e.rnd = rnd;
    pending_q.push_back(e);
    n_queued++;
  endtask

  task automatic queue_random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 78)      queue_event(itsq_pkg::EV_TICK,  16'($urandom_range(0, 65535)));
    else if (pick < 86) queue_event(itsq_pkg::EV_START, 16'($urandom_range(0, 65535)));
    else if (pick < 93) queue_event(itsq_pkg::EV_PAUSE, 16'($urandom_range(0, 65535)));
    else                queue_event(itsq_pkg::EV_SKIP,  16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      itsq_pkg::REG_WORK_MIN:   cfg_work_min    = val;
      itsq_pkg::REG_WORK_MAX:   cfg_work_max    = val;
      itsq_pkg::REG_REST_MIN:   cfg_rest_min    = val;
      itsq_pkg::REG_REST_MAX:   cfg_rest_max    = val;
      itsq_pkg::REG_REPEAT_MD:  cfg_repeat_mode = val[1:0];
      itsq_pkg::REG_REPEAT_LIM: cfg_repeat_lim  = val;
      itsq_pkg::REG_START_WARN: cfg_start_warn  = val[0];
      itsq_pkg::REG_END_WARN:   cfg_end_warn    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timer(input logic [7:0] wmin, input logic [7:0] wmax,
                           input logic [7:0] rmin, input logic [7:0] rmax,
                           input logic [7:0] rmode, input logic [7:0] rlim,
                           input logic [7:0] swarn, input logic [7:0] ewarn);
    write_reg(itsq_pkg::REG_WORK_MIN, wmin);
    write_reg(itsq_pkg::REG_WORK_MAX, wmax);
    write_reg(itsq_pkg::REG_REST_MIN, rmin);
    write_reg(itsq_pkg::REG_REST_MAX, rmax);
    write_reg(itsq_pkg::REG_REPEAT_MD, rmode);
    write_reg(itsq_pkg::REG_REPEAT_LIM, rlim);
    write_reg(itsq_pkg::REG_START_WARN, swarn);
    write_reg(itsq_pkg::REG_END_WARN, ewarn);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed run on the reset defaults
    queue_event(itsq_pkg::EV_TICK, 16'h0000);     // tick, pause and skip while idle
    queue_event(itsq_pkg::EV_PAUSE, 16'h0000);
    queue_event(itsq_pkg::EV_SKIP, 16'hFFFF);
    queue_event(itsq_pkg::EV_START, 16'hFFFF);
    for (int i = 0; i < START_COUNT; i++)
      queue_event(itsq_pkg::EV_TICK, (i % 2 == 0) ? 16'h0000 : 16'hFFFF);
    queue_event(itsq_pkg::EV_PAUSE, 16'h1234);    // work paused
    queue_event(itsq_pkg::EV_TICK, 16'hFFFF);     // ignored while paused
    queue_event(itsq_pkg::EV_SKIP, 16'h0000);     // no effect while paused
    queue_event(itsq_pkg::EV_PAUSE, 16'hFFFF);    // resume
    queue_event(itsq_pkg::EV_SKIP, 16'h00FF);
    queue_event(itsq_pkg::EV_TICK, 16'h0000);     // work over, enter rest
    queue_event(itsq_pkg::EV_PAUSE, 16'hFF00);
    queue_event(itsq_pkg::EV_TICK, 16'h0000);
    queue_event(itsq_pkg::EV_PAUSE, 16'hAAAA);
    queue_event(itsq_pkg::EV_TICK, 16'h5555);
    queue_event(itsq_pkg::EV_SKIP, 16'h0000);
    queue_event(itsq_pkg::EV_TICK, 16'hFFFF);     // rest over, back to work
    queue_event(itsq_pkg::EV_START, 16'h5A5A);    // restart mid-phase
    wait_drained();

    for (int s = 0; s < 8; s++) begin
      if (s < 3) begin
        send_idle_pct = 25;
        stall_pct     = 69;
      end else if (s < 6) begin
        send_idle_pct = 69;
        stall_pct     = 25;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      case (s)
        0: set_timer(8'd0, 8'd0, 8'd0, 8'd0, itsq_pkg::RM_ROUNDS, 8'd255, 8'd0, 8'd1);
        1: set_timer(8'd255, 8'd255, 8'd0, 8'd255, itsq_pkg::RM_SECONDS, 8'd255, 8'd1, 8'd0);
        // max below min; upper data bits masked, leaving the unnamed mode three
        2: set_timer(8'd20, 8'd5, 8'd9, 8'd2, 8'hFF, 8'd4, 8'hFF, 8'hFE);
        // zero limit stops on the start itself
        3: set_timer(8'd0, 8'd7, 8'd0, 8'd3, itsq_pkg::RM_SECONDS, 8'd0, 8'd1, 8'd1);
        4: set_timer(8'd0, 8'd255, 8'd0, 8'd255, itsq_pkg::RM_FOREVER,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        default: set_timer(8'($urandom_range(0, 6)), 8'($urandom_range(0, 12)),
                           8'($urandom_range(0, 4)), 8'($urandom_range(0, 8)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      // hold results long enough for the block to back up into its input
      if (s == 6) hold_reqs++;
      // every run starts from a start transfer
      queue_event(itsq_pkg::EV_START, 16'($urandom_range(0, 65535)));
      for (int i = 0; i < SEG_EVENTS; i++) queue_random_event();
      wait_drained();
    end

    if (n_errors == 0)
      $display("interval_timer_sequencer_tb passed");
    else
      $display("interval_timer_sequencer_tb failed");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("interval_timer_sequencer_tb failed");
    $finish;
  end

endmodule
